// File: hw/rtl/hsu_pkg.sv
// shared types and constants for the rgb to hue / saturation unit
`default_nettype none
package hsu_pkg;

  // pixel component width
  localparam int unsigned COMP_W   = 8;
  // hue numerator 1023*pos, pos below 6*255
  localparam int unsigned HREM_W   = 21;
  // hue divisor 6*delta
  localparam int unsigned HDEN_W   = 11;
  // hue sector position 0..6*delta-1
  localparam int unsigned POS_W    = 11;
  // saturation numerator 255*delta
  localparam int unsigned SREM_W   = 16;
  // saturation divisor max
  localparam int unsigned SDEN_W   = 8;
  // wide compare for the shifted saturation divisor
  localparam int unsigned SCMP_W   = 18;
  // quotient bits, one cell each
  localparam int unsigned Q_W      = 10;
  localparam int unsigned SAT_W    = 8;
  localparam int unsigned NUM_CELLS = Q_W;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 24;

  // word handed from cell to cell: partial remainders, divisors and quotients
  typedef struct packed {
    logic [HREM_W-1:0] hrem;
    logic [HDEN_W-1:0] hden;
    logic [Q_W-1:0]    hq;
    logic [SREM_W-1:0] srem;
    logic [SDEN_W-1:0] sden;
    logic [Q_W-1:0]    sq;
  } div_word_t;

endpackage
`default_nettype wire

// File: hw/rtl/hsu_front.sv
// front end: max, min, sector position, then scaled numerators and divisors
`default_nettype none
module hsu_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic [hsu_pkg::COMP_W-1:0] red,
  input  wire logic [hsu_pkg::COMP_W-1:0] green,
  input  wire logic [hsu_pkg::COMP_W-1:0] blue,
  output logic                           out_valid,
  output hsu_pkg::div_word_t             out_word
);
  import hsu_pkg::*;

  logic [COMP_W-1:0] mx, mn, delta;
  logic [POS_W-1:0]  d2, d4, d6, pos;
  logic [POS_W-1:0]  r_e, g_e, b_e;

  logic              va_r;
  logic [COMP_W-1:0] mx_r, delta_r;
  logic [POS_W-1:0]  pos_r;

  logic              vb_r;
  div_word_t         word_r, word_nxt;

  // max, min and spread of the pixel
  always_comb begin
    mx = (red > green) ? red : green;
    if (blue > mx) begin
      mx = blue;
    end
    mn = (red < green) ? red : green;
    if (blue < mn) begin
      mn = blue;
    end
    delta = mx - mn;
  end

  // position within the color circle, in units of delta, red wins ties
  always_comb begin
    r_e = {{(POS_W-COMP_W){1'b0}}, red};
    g_e = {{(POS_W-COMP_W){1'b0}}, green};
    b_e = {{(POS_W-COMP_W){1'b0}}, blue};
    d2  = {{(POS_W-COMP_W-1){1'b0}}, delta, 1'b0};
    d4  = {{(POS_W-COMP_W-2){1'b0}}, delta, 2'b00};
    d6  = d4 + d2;
    if (mx == red) begin
      if (green >= blue) begin
        pos = g_e - b_e;
      end else begin
        pos = d6 - (b_e - g_e);
      end
    end else if (mx == green) begin
      pos = d2 + b_e - r_e;
    end else begin
      pos = d4 + r_e - g_e;
    end
  end

  // first stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r    <= mx;
      delta_r <= delta;
      pos_r   <= pos;
    end
  end

  // numerators scaled by 1023 and 255, divisors kept nonzero
  always_comb begin
    word_nxt      = '0;
    word_nxt.hrem = {pos_r, {(HREM_W-POS_W){1'b0}}} - {{(HREM_W-POS_W){1'b0}}, pos_r};
    if (delta_r == '0) begin
      word_nxt.hden = HDEN_W'(1);
    end else begin
      word_nxt.hden = {{(HDEN_W-COMP_W-2){1'b0}}, delta_r, 2'b00}
                    + {{(HDEN_W-COMP_W-1){1'b0}}, delta_r, 1'b0};
    end
    word_nxt.srem = {delta_r, {(SREM_W-COMP_W){1'b0}}}
                  - {{(SREM_W-COMP_W){1'b0}}, delta_r};
    word_nxt.sden = (mx_r == '0) ? SDEN_W'(1) : mx_r;
  end

  // second stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = vb_r;
  assign out_word  = word_r;

endmodule
`default_nettype wire

// File: hw/rtl/hsu_div_cell.sv
// one restoring division cell: settles one quotient bit of hue and of saturation
`default_nettype none
module hsu_div_cell #(
  parameter int unsigned BitIdx = 0
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  hsu_pkg::div_word_t      in_word,
  output logic                    out_valid,
  output hsu_pkg::div_word_t      out_word
);
  import hsu_pkg::*;

  logic [HREM_W-1:0] hden_sh;
  logic [SCMP_W-1:0] sden_sh;
  logic              hfit, sfit;
  logic              valid_r;
  div_word_t         word_r, word_nxt;

  // trial subtract of the divisor at this bit weight
  always_comb begin
    hden_sh  = {{(HREM_W-HDEN_W){1'b0}}, in_word.hden} << BitIdx;
    sden_sh  = {{(SCMP_W-SDEN_W){1'b0}}, in_word.sden} << BitIdx;
    hfit     = in_word.hrem >= hden_sh;
    sfit     = {{(SCMP_W-SREM_W){1'b0}}, in_word.srem} >= sden_sh;
    word_nxt = in_word;
    if (hfit) begin
      word_nxt.hrem       = in_word.hrem - hden_sh;
      word_nxt.hq[BitIdx] = 1'b1;
    end
    if (sfit) begin
      word_nxt.srem       = in_word.srem - sden_sh[SREM_W-1:0];
      word_nxt.sq[BitIdx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule
`default_nettype wire

// File: hw/rtl/rgb_to_hue_saturation_unit.sv
// top level of the rgb to hue / saturation unit
//
// The slave channel takes one rgb pixel per word, red in the low byte. The
// master channel returns hue (0..1022, a full turn scaled by 1023) and
// saturation (0..255), both truncated. Grey and black pixels give hue 0.
// The datapath is a front end of two register stages followed by a row of
// ten division cells, one quotient bit per cell. That makes twelve register
// stages, front end first. One pixel is accepted in every cycle unless the
// receiver stalls; that rate is set by the division row, where every cell
// works on a different pixel.
// All stages advance together whenever the master side takes a word or the
// last cell holds nothing; while the receiver stalls with a word waiting,
// the whole row holds and in_tready drops in the same cycle.
// Reset clears all valid bits and holds in_tready low; no word is shown
// until a pixel has gone through the row.
`default_nettype none
module rgb_to_hue_saturation_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // red [7:0], green [15:8], blue [23:16]
  input  wire logic [hsu_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // hue_out [9:0], saturation_out [17:10], zeros above
  output logic [hsu_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import hsu_pkg::*;

  logic      en;
  logic      chain_v [NUM_CELLS+1];
  div_word_t chain_w [NUM_CELLS+1];

  // whole row advances unless a finished word is stalled
  assign en        = out_tready || !chain_v[NUM_CELLS];
  assign in_tready = en && rst_n;

  hsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .red       (in_tdata[COMP_W-1:0]),
    .green     (in_tdata[2*COMP_W-1:COMP_W]),
    .blue      (in_tdata[3*COMP_W-1:2*COMP_W]),
    .out_valid (chain_v[0]),
    .out_word  (chain_w[0])
  );

  // division row, most significant quotient bit first
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    hsu_div_cell #(
      .BitIdx (NUM_CELLS - 1 - k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (chain_v[k]),
      .in_word   (chain_w[k]),
      .out_valid (chain_v[k+1]),
      .out_word  (chain_w[k+1])
    );
  end

  // result word from the last cell
  assign out_tvalid = chain_v[NUM_CELLS];
  assign out_tdata  = {{(OUT_DATA_W-Q_W-SAT_W){1'b0}},
                       chain_w[NUM_CELLS].sq[SAT_W-1:0],
                       chain_w[NUM_CELLS].hq};

endmodule
`default_nettype wire
